// ===== rtl/core/multilevel_queue_slot_scheduler_core_defines.svh =====
// Assertion macros for the multilevel queue slot scheduler checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MULTILEVEL_QUEUE_SLOT_SCHEDULER_CORE_DEFINES_SVH
`define MULTILEVEL_QUEUE_SLOT_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, reset masked
`define MLQS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed in %m");

// Next-cycle implication, reset masked
`define MLQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed in %m");

`endif

// ===== rtl/core/mlqs_pkg.sv =====
// Shared constants for the multilevel queue slot scheduler.
// No dependencies; imported by the core, the level search and the checker.
package mlqs_pkg;

    // Default configuration
    localparam int NUM_LEVELS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Fixed field widths
    localparam int ID_W   = 8;
    localparam int PRIO_W = 3;

    // Request opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_PICK = 1'b1;

endpackage

// ===== rtl/core/multilevel_queue_slot_scheduler_core.sv =====
// Multilevel ready-queue slot scheduler: one FIFO of ids per level, weighted
// round robin between levels. Requests are handled one at a time: the per-level
// pointer memory is read and written back, then for a pick the id memory is
// read; both memories have a registered read. A result stalled at the output
// only delays the block if the next result is ready before the old one is taken.
// Reset needs no clearing pass: per-level valid bits stand for the reset state.
// Depends on mlqs_pkg, mlqs_ram and mlqs_level_sel.
module multilevel_queue_slot_scheduler_core #(
    parameter int NUM_LEVELS  = mlqs_pkg::NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = mlqs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        op,
    input  logic [mlqs_pkg::ID_W-1:0]   proc_id,
    input  logic [mlqs_pkg::PRIO_W-1:0] prio,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [mlqs_pkg::ID_W-1:0]   out_id,
    output logic [mlqs_pkg::PRIO_W-1:0] out_prio,
    output logic                        dropped,
    output logic                        all_empty
);

    import mlqs_pkg::*;

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CRD_W  = $clog2(NUM_LEVELS + 1);
    localparam int QDEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int QADR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] cnt;
        logic [CRD_W-1:0] crd;
    } meta_t;

    localparam int META_W = $bits(meta_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_DATA,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic                  op_reg, op_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic                  skip_reg, skip_next;
    logic [LVL_W-1:0]      cur_lvl_reg, cur_lvl_next;
    logic [NUM_LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [NUM_LEVELS-1:0] mvalid_reg, mvalid_next;

    // pending result
    logic                  res_found_reg, res_found_next;
    logic [ID_W-1:0]       res_id_reg, res_id_next;
    logic [PRIO_W-1:0]     res_prio_reg, res_prio_next;
    logic                  res_drop_reg, res_drop_next;
    logic                  res_empty_reg, res_empty_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg, found_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;
    logic [PRIO_W-1:0]     out_prio_reg, out_prio_next;
    logic                  dropped_reg, dropped_next;
    logic                  all_empty_reg, all_empty_next;

    // memory ports
    logic                  meta_rd_en, meta_wr_en;
    logic [LVL_W-1:0]      meta_rd_addr;
    logic [META_W-1:0]     meta_rdata, meta_wdata;
    logic                  q_rd_en, q_wr_en;
    logic [QADR_W-1:0]     q_rd_addr, q_wr_addr;
    logic [ID_W-1:0]       q_rdata;

    // datapath
    logic                  pick_hit;
    logic [LVL_W-1:0]      pick_lvl;
    logic [LVL_W-1:0]      sel_lvl;
    logic                  sel_skip;
    meta_t                 meta_cur, meta_upd;
    logic                  level_full;
    logic [PTR_W-1:0]      head_inc, tail_inc;
    logic [CNT_W-1:0]      cnt_dec;
    logic [CRD_W-1:0]      crd_dec, crd_full;
    logic                  refill;
    logic [LVL_W-1:0]      lvl_wrap;
    logic [QADR_W-1:0]     q_base;
    logic [NUM_LEVELS-1:0] nonempty_upd;
    logic                  out_free;
    logic                  emit;
    logic                  e_found, e_drop, e_empty;
    logic [ID_W-1:0]       e_id;
    logic [PRIO_W-1:0]     e_prio;

    mlqs_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_LEVELS)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (meta_wr_en),
        .wr_addr (lvl_reg),
        .wr_data (meta_wdata),
        .rd_en   (meta_rd_en),
        .rd_addr (meta_rd_addr),
        .rd_data (meta_rdata)
    );

    mlqs_ram #(
        .WIDTH (ID_W),
        .DEPTH (QDEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (id_reg),
        .rd_en   (q_rd_en),
        .rd_addr (q_rd_addr),
        .rd_data (q_rdata)
    );

    mlqs_level_sel #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_level_sel (
        .busy  (nonempty_reg),
        .start (cur_lvl_reg),
        .hit   (pick_hit),
        .level (pick_lvl)
    );

    // level chosen at request time; out-of-range add or empty pick is skipped
    always_comb
    begin
        if (op == OP_ADD)
        begin
            sel_lvl  = LVL_W'(prio);
            sel_skip = (int'(prio) >= NUM_LEVELS);
        end
        else
        begin
            sel_lvl  = pick_lvl;
            sel_skip = !pick_hit;
        end
    end

    // level record, reset value until first written
    always_comb
    begin
        if (mvalid_reg[lvl_reg])
        begin
            meta_cur = meta_t'(meta_rdata);
        end
        else
        begin
            meta_cur.head = '0;
            meta_cur.tail = '0;
            meta_cur.cnt  = '0;
            meta_cur.crd  = crd_full;
        end
    end

    // pointer, count and credit arithmetic
    assign crd_full   = CRD_W'(NUM_LEVELS) - CRD_W'(lvl_reg);
    assign level_full = meta_cur.cnt >= CNT_W'(QUEUE_DEPTH);
    assign head_inc   = (meta_cur.head == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : meta_cur.head + PTR_W'(1);
    assign tail_inc   = (meta_cur.tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : meta_cur.tail + PTR_W'(1);
    assign cnt_dec    = meta_cur.cnt - CNT_W'(1);
    assign crd_dec    = (meta_cur.crd != '0) ? meta_cur.crd - CRD_W'(1) : meta_cur.crd;
    assign refill     = (crd_dec == '0) || (cnt_dec == '0);
    assign lvl_wrap   = (lvl_reg == LVL_W'(NUM_LEVELS - 1)) ? '0 : lvl_reg + LVL_W'(1);
    assign q_base     = QADR_W'(lvl_reg) * QADR_W'(QUEUE_DEPTH);
    assign out_free   = !out_valid_reg || !out_stall;

    // control and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        lvl_next       = lvl_reg;
        skip_next      = skip_reg;
        cur_lvl_next   = cur_lvl_reg;
        nonempty_next  = nonempty_reg;
        mvalid_next    = mvalid_reg;
        res_found_next = res_found_reg;
        res_id_next    = res_id_reg;
        res_prio_next  = res_prio_reg;
        res_drop_next  = res_drop_reg;
        res_empty_next = res_empty_reg;
        meta_rd_en     = 1'b0;
        meta_rd_addr   = sel_lvl;
        meta_wr_en     = 1'b0;
        meta_upd       = meta_cur;
        q_rd_en        = 1'b0;
        q_rd_addr      = q_base + QADR_W'(meta_cur.head);
        q_wr_en        = 1'b0;
        q_wr_addr      = q_base + QADR_W'(meta_cur.tail);
        nonempty_upd   = nonempty_reg;
        emit           = 1'b0;
        e_found        = res_found_reg;
        e_id           = res_id_reg;
        e_prio         = res_prio_reg;
        e_drop         = res_drop_reg;
        e_empty        = res_empty_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    id_next    = proc_id;
                    lvl_next   = sel_lvl;
                    skip_next  = sel_skip;
                    meta_rd_en = 1'b1;
                    state_next = S_META;
                end
            end

            S_META:
            begin
                e_found = 1'b0;
                e_id    = '0;
                e_prio  = '0;
                e_drop  = 1'b0;
                if (op_reg == OP_ADD)
                begin
                    if (skip_reg || level_full)
                    begin
                        e_drop = 1'b1;
                    end
                    else
                    begin
                        q_wr_en                = 1'b1;
                        meta_upd.tail          = tail_inc;
                        meta_upd.cnt           = meta_cur.cnt + CNT_W'(1);
                        meta_wr_en             = 1'b1;
                        mvalid_next[lvl_reg]   = 1'b1;
                        nonempty_upd[lvl_reg]  = 1'b1;
                    end
                    e_empty = ~|nonempty_upd;
                    emit    = 1'b1;
                end
                else if (skip_reg)
                begin
                    e_empty = ~|nonempty_reg;
                    emit    = 1'b1;
                end
                else
                begin
                    q_rd_en               = 1'b1;
                    meta_upd.head         = head_inc;
                    meta_upd.cnt          = cnt_dec;
                    meta_upd.crd          = refill ? crd_full : crd_dec;
                    meta_wr_en            = 1'b1;
                    mvalid_next[lvl_reg]  = 1'b1;
                    nonempty_upd[lvl_reg] = (cnt_dec != '0);
                    cur_lvl_next          = refill ? lvl_wrap : lvl_reg;
                    res_found_next        = 1'b1;
                    res_prio_next         = PRIO_W'(lvl_reg);
                    res_drop_next         = 1'b0;
                    res_empty_next        = ~|nonempty_upd;
                    state_next            = S_DATA;
                end
                nonempty_next = nonempty_upd;
            end

            S_DATA:
            begin
                e_id = q_rdata;
                emit = 1'b1;
            end

            S_EMIT:
            begin
                emit = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result to the output register, or park it
        if (emit)
        begin
            if (out_free)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                res_found_next = e_found;
                res_id_next    = e_id;
                res_prio_next  = e_prio;
                res_drop_next  = e_drop;
                res_empty_next = e_empty;
                state_next     = S_EMIT;
            end
        end
    end

    assign meta_wdata = META_W'(meta_upd);

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        out_id_next    = out_id_reg;
        out_prio_next  = out_prio_reg;
        dropped_next   = dropped_reg;
        all_empty_next = all_empty_reg;
        if (emit && out_free)
        begin
            out_valid_next = 1'b1;
            found_next     = e_found;
            out_id_next    = e_id;
            out_prio_next  = e_prio;
            dropped_next   = e_drop;
            all_empty_next = e_empty;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_ADD;
            id_reg        <= '0;
            lvl_reg       <= '0;
            skip_reg      <= 1'b0;
            cur_lvl_reg   <= '0;
            nonempty_reg  <= '0;
            mvalid_reg    <= '0;
            res_found_reg <= 1'b0;
            res_id_reg    <= '0;
            res_prio_reg  <= '0;
            res_drop_reg  <= 1'b0;
            res_empty_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_id_reg    <= '0;
            out_prio_reg  <= '0;
            dropped_reg   <= 1'b0;
            all_empty_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            id_reg        <= id_next;
            lvl_reg       <= lvl_next;
            skip_reg      <= skip_next;
            cur_lvl_reg   <= cur_lvl_next;
            nonempty_reg  <= nonempty_next;
            mvalid_reg    <= mvalid_next;
            res_found_reg <= res_found_next;
            res_id_reg    <= res_id_next;
            res_prio_reg  <= res_prio_next;
            res_drop_reg  <= res_drop_next;
            res_empty_reg <= res_empty_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            out_id_reg    <= out_id_next;
            out_prio_reg  <= out_prio_next;
            dropped_reg   <= dropped_next;
            all_empty_reg <= all_empty_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign out_id    = out_id_reg;
    assign out_prio  = out_prio_reg;
    assign dropped   = dropped_reg;
    assign all_empty = all_empty_reg;

endmodule

// ===== rtl/core/mlqs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mlqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/mlqs_level_sel.sv =====
// Level search: first non-empty level at or after the start level, wrapping once.
// Depends on mlqs_pkg.
module mlqs_level_sel #(
    parameter int NUM_LEVELS = mlqs_pkg::NUM_LEVELS_DEF
) (
    input  logic [NUM_LEVELS-1:0]         busy,
    input  logic [$clog2(NUM_LEVELS)-1:0] start,
    output logic                          hit,
    output logic [$clog2(NUM_LEVELS)-1:0] level
);

    import mlqs_pkg::*;

    localparam int LVL_W = $clog2(NUM_LEVELS);

    logic [NUM_LEVELS-1:0] upper;
    logic [LVL_W-1:0]      lvl_hi;
    logic [LVL_W-1:0]      lvl_any;

    // busy levels at or above the start level
    always_comb
    begin
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            upper[i] = busy[i] && (LVL_W'(i) >= start);
        end
    end

    // lowest set bit of each vector
    always_comb
    begin
        lvl_hi  = '0;
        lvl_any = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (upper[i])
            begin
                lvl_hi = LVL_W'(i);
            end
            if (busy[i])
            begin
                lvl_any = LVL_W'(i);
            end
        end
    end

    // wrap to the bottom only when nothing is left at or above the start
    assign hit   = |busy;
    assign level = (|upper) ? lvl_hi : lvl_any;

endmodule

// ===== rtl/core/mlqs_checker.sv =====
// Port-level checks for the multilevel queue slot scheduler, bound to the top.
// Depends on mlqs_pkg and multilevel_queue_slot_scheduler_core_defines.svh.
`include "multilevel_queue_slot_scheduler_core_defines.svh"

module mlqs_checker #(
    parameter int NUM_LEVELS = mlqs_pkg::NUM_LEVELS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        found,
    input logic [mlqs_pkg::ID_W-1:0]   out_id,
    input logic [mlqs_pkg::PRIO_W-1:0] out_prio,
    input logic                        dropped,
    input logic                        all_empty
);

    import mlqs_pkg::*;

    localparam int RES_W = ID_W + PRIO_W + 3;

    logic [RES_W-1:0] res_bus;
    logic             miss_zero;
    logic             prio_ok;

    // whole result as one vector, plus the per-case conditions
    assign res_bus   = {found, out_id, out_prio, dropped, all_empty};
    assign miss_zero = (out_id == '0) && (out_prio == '0);
    assign prio_ok   = int'(out_prio) < NUM_LEVELS;

    // one request in flight: the cycle after acceptance the input is held off
    `MLQS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // a stalled result stays put
    `MLQS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(res_bus))

    // no process found: id and level read zero
    `MLQS_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_valid && !found, miss_zero)

    // a pick never reports a drop, and its level exists
    `MLQS_ASSERT_IMPL(a_found_level, clk, rst_n, out_valid && found, !dropped && prio_ok)

endmodule

bind multilevel_queue_slot_scheduler_core mlqs_checker #(
    .NUM_LEVELS (NUM_LEVELS)
) u_mlqs_checker (.*);
